// File: hw/rtl/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and constants for the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int SIDE_DEPTH_DEF = 16;
  localparam int PRICE_BITS_DEF = 32;

  localparam logic [2:0] KIND_FILL      = 3'd0;
  localparam logic [2:0] KIND_DONE      = 3'd1;
  localparam logic [2:0] KIND_CANCELLED = 3'd2;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [2:0] KIND_REJECT    = 3'd4;

  localparam logic FUNC_NEW    = 1'b0;
  localparam logic FUNC_CANCEL = 1'b1;
  localparam logic SIDE_BID    = 1'b0;
  localparam logic SIDE_ASK    = 1'b1;

  typedef enum logic [2:0] {
    SIDE_NOP,
    SIDE_SUB,
    SIDE_POP,
    SIDE_INS,
    SIDE_CAN
  } side_op_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHL,
    CELL_SHR,
    CELL_LOAD,
    CELL_SUB
  } cell_op_t;

  typedef struct packed {
    side_op_t    op;
    logic [31:0] qty;
    logic [31:0] id;
  } side_cmd_t;

  typedef struct packed {
    logic        hv;
    logic [31:0] hq;
    logic [31:0] hid;
    logic        full;
    logic        found;
    logic [31:0] fqty;
  } side_stat_t;

endpackage

// File: hw/rtl/lobm_cell.sv
// ----------------------------------------------------------------------------
// lobm_cell
// One book slot: holds an order and shifts to or from its neighbours.
// ----------------------------------------------------------------------------
module lobm_cell
  import lobm_pkg::*;
#(
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_op_t              op,
  input  logic [PRICE_BITS-1:0] new_px,
  input  logic [31:0]           new_qty,
  input  logic [31:0]           new_id,
  input  logic                  l_v,
  input  logic [PRICE_BITS-1:0] l_px,
  input  logic [31:0]           l_qty,
  input  logic [31:0]           l_id,
  input  logic                  r_v,
  input  logic [PRICE_BITS-1:0] r_px,
  input  logic [31:0]           r_qty,
  input  logic [31:0]           r_id,
  output logic                  v,
  output logic [PRICE_BITS-1:0] px,
  output logic [31:0]           qty,
  output logic [31:0]           id
);

  logic                  v_r;
  logic [PRICE_BITS-1:0] px_r;
  logic [31:0]           qty_r, id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      case (op)
        CELL_SHL:  v_r <= r_v;
        CELL_SHR:  v_r <= l_v;
        CELL_LOAD: v_r <= 1'b1;
        default:   v_r <= v_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      CELL_SHL: begin
        px_r <= r_px; qty_r <= r_qty; id_r <= r_id;
      end
      CELL_SHR: begin
        px_r <= l_px; qty_r <= l_qty; id_r <= l_id;
      end
      CELL_LOAD: begin
        px_r <= new_px; qty_r <= new_qty; id_r <= new_id;
      end
      CELL_SUB: qty_r <= qty_r - new_qty;
      default: ;
    endcase
  end

  assign v   = v_r;
  assign px  = px_r;
  assign qty = qty_r;
  assign id  = id_r;

endmodule

// File: hw/rtl/lobm_side.sv
// ----------------------------------------------------------------------------
// lobm_side
// One side of the book as a sorted row of cells, best order at cell 0.
// ----------------------------------------------------------------------------
module lobm_side
  import lobm_pkg::*;
#(
  parameter int   SIDE_DEPTH = SIDE_DEPTH_DEF,
  parameter int   PRICE_BITS = PRICE_BITS_DEF,
  parameter logic ASK        = 1'b0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  side_cmd_t             cmd,
  input  logic [PRICE_BITS-1:0] cmd_px,
  output side_stat_t            stat,
  output logic [PRICE_BITS-1:0] head_px
);

  logic                  v   [SIDE_DEPTH+1];
  logic [PRICE_BITS-1:0] px  [SIDE_DEPTH+1];
  logic [31:0]           qty [SIDE_DEPTH+1];
  logic [31:0]           id  [SIDE_DEPTH+1];
  logic                  seen[SIDE_DEPTH+1];
  logic                  ahead[SIDE_DEPTH];
  logic                  first[SIDE_DEPTH];
  logic [31:0]           fqty;

  assign v[SIDE_DEPTH]    = 1'b0;
  assign px[SIDE_DEPTH]   = '0;
  assign qty[SIDE_DEPTH]  = '0;
  assign id[SIDE_DEPTH]   = '0;
  assign seen[0]          = 1'b0;

  for (genvar j = 0; j < SIDE_DEPTH; j++) begin : g_cell
    logic                  m;
    logic                  prev;
    logic                  lv;
    logic [PRICE_BITS-1:0] lpx;
    logic [31:0]           lqty, lid;
    cell_op_t              op;

    assign m        = v[j] && (id[j] == cmd.id);
    assign first[j] = m && !seen[j];
    assign seen[j+1] = seen[j] | m;
    assign ahead[j] = !v[j] || (ASK ? (cmd_px < px[j]) : (cmd_px > px[j]));

    if (j == 0) begin : g_head
      assign prev = 1'b0;
      assign lv   = 1'b0;
      assign lpx  = '0;
      assign lqty = '0;
      assign lid  = '0;
    end else begin : g_body
      assign prev = ahead[j-1];
      assign lv   = v[j-1];
      assign lpx  = px[j-1];
      assign lqty = qty[j-1];
      assign lid  = id[j-1];
    end

    always_comb begin
      op = CELL_HOLD;
      unique case (cmd.op)
        SIDE_SUB: op = (j == 0) ? CELL_SUB : CELL_HOLD;
        SIDE_POP: op = CELL_SHL;
        SIDE_INS: op = ahead[j] ? (prev ? CELL_SHR : CELL_LOAD) : CELL_HOLD;
        SIDE_CAN: op = (seen[j] || m) ? CELL_SHL : CELL_HOLD;
        default:  op = CELL_HOLD;
      endcase
    end

    lobm_cell #(.PRICE_BITS(PRICE_BITS)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .op      (op),
      .new_px  (cmd_px),
      .new_qty (cmd.qty),
      .new_id  (cmd.id),
      .l_v     (lv),
      .l_px    (lpx),
      .l_qty   (lqty),
      .l_id    (lid),
      .r_v     (v[j+1]),
      .r_px    (px[j+1]),
      .r_qty   (qty[j+1]),
      .r_id    (id[j+1]),
      .v       (v[j]),
      .px      (px[j]),
      .qty     (qty[j]),
      .id      (id[j])
    );
  end

  always_comb begin
    fqty = '0;
    for (int j = 0; j < SIDE_DEPTH; j++) begin
      fqty = fqty | (first[j] ? qty[j] : 32'd0);
    end
  end

  assign stat.fqty  = fqty;
  assign stat.hv    = v[0];
  assign stat.hq    = qty[0];
  assign stat.hid   = id[0];
  assign stat.full  = v[SIDE_DEPTH-1];
  assign stat.found = seen[SIDE_DEPTH];
  assign head_px    = px[0];

endmodule

// File: hw/rtl/limit_order_book_matcher_core.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core
// One-symbol price-time priority order book with matching.
// ----------------------------------------------------------------------------
// Flow: a cancel goes to S_CANCEL and registers its result there; a new order
// registers a fill per step in S_MATCH, then its final result in S_FINAL.
// Throughput: one request in flight; a new order is taken once the last
// result is registered. Each fill is one head update of the opposite cell row.
// Reset: synchronous, active low; both sides empty, output channel idle.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_core
  import lobm_pkg::*;
#(
  parameter int SIDE_DEPTH = SIDE_DEPTH_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic        in_side,
  input  logic [31:0] in_price,
  input  logic [31:0] in_quantity,
  input  logic [31:0] in_order_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [31:0] out_resting_id,
  output logic [31:0] out_incoming_id,
  output logic [31:0] out_fill_price,
  output logic [31:0] out_fill_qty,
  output logic        out_resting_filled,
  output logic        out_incoming_filled,
  output logic [31:0] out_remaining_qty,
  output logic        out_last
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MATCH  = 4'b0010,
    S_FINAL  = 4'b0100,
    S_CANCEL = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic                  side_r;
  logic [PRICE_BITS-1:0] px_r;
  logic [31:0]           rem_r, rem_nxt, id_r;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [31:0] rid_r, rid_nxt, fpx_r, fpx_nxt, fq_r, fq_nxt, orem_r, orem_nxt;
  logic [31:0] iid_r, iid_nxt;
  logic        rf_r, rf_nxt, inf_r, inf_nxt, last_r, last_nxt;

  side_cmd_t             bid_cmd, ask_cmd;
  side_stat_t            bid_st, ask_st, opp_st, own_st;
  logic [PRICE_BITS-1:0] bid_hpx, ask_hpx, opp_hpx;
  side_op_t              opp_op, own_op;
  logic                  can_emit, crosses, take;
  logic [31:0]           f;

  assign in_ready = (state_r == S_IDLE);
  assign can_emit = !out_valid_r || out_ready;

  assign opp_st  = side_r ? bid_st : ask_st;
  assign own_st  = side_r ? ask_st : bid_st;
  assign opp_hpx = side_r ? bid_hpx : ask_hpx;
  assign crosses = side_r ? (px_r <= opp_hpx) : (px_r >= opp_hpx);
  assign take    = (rem_r != 32'd0) && opp_st.hv && crosses;
  assign f       = (rem_r < opp_st.hq) ? rem_r : opp_st.hq;

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    opp_op        = SIDE_NOP;
    own_op        = SIDE_NOP;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    rid_nxt       = rid_r;
    iid_nxt       = iid_r;
    fpx_nxt       = fpx_r;
    fq_nxt        = fq_r;
    rf_nxt        = rf_r;
    inf_nxt       = inf_r;
    orem_nxt      = orem_r;
    last_nxt      = last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rem_nxt   = in_quantity;
          state_nxt = (in_func == FUNC_NEW) ? S_MATCH : S_CANCEL;
        end
      end
      S_MATCH: begin
        if (!take) begin
          state_nxt = S_FINAL;
        end else if (can_emit) begin
          rem_nxt       = rem_r - f;
          opp_op        = (f == opp_st.hq) ? SIDE_POP : SIDE_SUB;
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_FILL;
          rid_nxt       = opp_st.hid;
          iid_nxt       = id_r;
          fpx_nxt       = 32'(opp_hpx);
          fq_nxt        = f;
          rf_nxt        = (f == opp_st.hq);
          inf_nxt       = (f == rem_r);
          orem_nxt      = rem_r - f;
          last_nxt      = 1'b0;
        end
      end
      S_FINAL: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          rid_nxt       = '0;
          iid_nxt       = id_r;
          fpx_nxt       = '0;
          fq_nxt        = '0;
          rf_nxt        = 1'b0;
          inf_nxt       = (rem_r == 32'd0);
          orem_nxt      = rem_r;
          last_nxt      = 1'b1;
          kind_nxt      = KIND_DONE;
          if (rem_r != 32'd0) begin
            if (own_st.full) begin
              kind_nxt = KIND_REJECT;
            end else begin
              own_op = SIDE_INS;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      S_CANCEL: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          iid_nxt       = id_r;
          fpx_nxt       = '0;
          fq_nxt        = '0;
          inf_nxt       = 1'b0;
          last_nxt      = 1'b1;
          own_op        = SIDE_CAN;
          kind_nxt      = own_st.found ? KIND_CANCELLED : KIND_NOT_FOUND;
          rid_nxt       = own_st.found ? id_r : 32'd0;
          rf_nxt        = own_st.found;
          orem_nxt      = own_st.found ? own_st.fqty : 32'd0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    bid_cmd.id  = id_r;
    ask_cmd.id  = id_r;
    bid_cmd.qty = (side_r == SIDE_BID) ? rem_r : f;
    ask_cmd.qty = (side_r == SIDE_BID) ? f : rem_r;
    bid_cmd.op  = (side_r == SIDE_BID) ? own_op : opp_op;
    ask_cmd.op  = (side_r == SIDE_BID) ? opp_op : own_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      side_r <= in_side;
      px_r   <= PRICE_BITS'(in_price);
      id_r   <= in_order_id;
    end
    rem_r  <= rem_nxt;
    kind_r <= kind_nxt;
    rid_r  <= rid_nxt;
    iid_r  <= iid_nxt;
    fpx_r  <= fpx_nxt;
    fq_r   <= fq_nxt;
    rf_r   <= rf_nxt;
    inf_r  <= inf_nxt;
    orem_r <= orem_nxt;
    last_r <= last_nxt;
  end

  lobm_side #(.SIDE_DEPTH(SIDE_DEPTH), .PRICE_BITS(PRICE_BITS), .ASK(1'b0)) u_bid (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (bid_cmd),
    .cmd_px  (px_r),
    .stat    (bid_st),
    .head_px (bid_hpx)
  );

  lobm_side #(.SIDE_DEPTH(SIDE_DEPTH), .PRICE_BITS(PRICE_BITS), .ASK(1'b1)) u_ask (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (ask_cmd),
    .cmd_px  (px_r),
    .stat    (ask_st),
    .head_px (ask_hpx)
  );

  assign out_valid           = out_valid_r;
  assign out_kind            = kind_r;
  assign out_resting_id      = rid_r;
  assign out_incoming_id     = iid_r;
  assign out_fill_price      = fpx_r;
  assign out_fill_qty        = fq_r;
  assign out_resting_filled  = rf_r;
  assign out_incoming_filled = inf_r;
  assign out_remaining_qty   = orem_r;
  assign out_last            = last_r;

endmodule

// File: tb/tb_limit_order_book_matcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_limit_order_book_matcher_core
// Drives limit orders and cancels into the matcher and compares every fill,
// rest, cancel and reject report against a price-time priority book model.
// ----------------------------------------------------------------------------
module tb_limit_order_book_matcher_core;
  import lobm_pkg::*;

  localparam int DEPTH = SIDE_DEPTH_DEF;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] rid;
    logic [31:0] iid;
    logic [31:0] price;
    logic [31:0] qty;
    logic        rf;
    logic        inf;
    logic [31:0] rem;
    logic        last;
  } report_t;

  class book_scoreboard;
    logic [31:0] px[2][$];
    logic [31:0] qt[2][$];
    logic [31:0] oid[2][$];
    report_t     pending[$];
    int          errors;
    int          fills;
    int          cancels;
    int          rejects;

    function void push(logic [2:0] kind, logic [31:0] rid, logic [31:0] iid,
                       logic [31:0] price, logic [31:0] qty, logic rf, logic inf,
                       logic [31:0] rem, logic last);
      report_t r;
      r.kind = kind; r.rid = rid; r.iid = iid; r.price = price; r.qty = qty;
      r.rf = rf; r.inf = inf; r.rem = rem; r.last = last;
      pending.push_back(r);
    endfunction

    function void note_request(logic func, logic side, logic [31:0] price,
                               logic [31:0] qty, logic [31:0] id);
      int          o;
      int          pos;
      logic [31:0] rem;
      logic [31:0] f;
      logic        crosses;
      logic        found;
      o = side ? 0 : 1;
      if (func != FUNC_NEW) begin
        found = 0;
        for (int k = 0; k < oid[side].size() && !found; k++) begin
          if (oid[side][k] == id) begin
            found = 1;
            push(KIND_CANCELLED, id, id, 0, 0, 1, 0, qt[side][k], 1);
            px[side].delete(k); qt[side].delete(k); oid[side].delete(k);
          end
        end
        if (!found) push(KIND_NOT_FOUND, 0, id, 0, 0, 0, 0, 0, 1);
        return;
      end
      rem = qty;
      while (rem != 0 && px[o].size() > 0) begin
        crosses = side ? (price <= px[o][0]) : (price >= px[o][0]);
        if (!crosses) break;
        f = (rem < qt[o][0]) ? rem : qt[o][0];
        qt[o][0] -= f;
        rem -= f;
        fills++;
        push(KIND_FILL, oid[o][0], id, px[o][0], f, qt[o][0] == 0, rem == 0, rem, 0);
        if (qt[o][0] == 0) begin
          px[o].pop_front(); qt[o].pop_front(); oid[o].pop_front();
        end
      end
      if (rem == 0) begin
        push(KIND_DONE, 0, id, 0, 0, 0, 1, 0, 1);
      end else if (px[side].size() < DEPTH) begin
        pos = 0;
        while (pos < px[side].size() &&
               (side ? !(px[side][pos] > price) : !(px[side][pos] < price)))
          pos++;
        px[side].insert(pos, price);
        qt[side].insert(pos, rem);
        oid[side].insert(pos, id);
        push(KIND_DONE, 0, id, 0, 0, 0, 0, rem, 1);
      end else begin
        rejects++;
        push(KIND_REJECT, 0, id, 0, 0, 0, 0, rem, 1);
      end
    endfunction

    function void check_report(report_t a);
      report_t e;
      if (pending.size() == 0) begin
        $error("unexpected report kind %0d id %0d", a.kind, a.iid);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.kind == KIND_CANCELLED) cancels++;
      if (a.kind !== e.kind) begin
        $error("kind exp %0d got %0d", e.kind, a.kind); errors++;
      end
      if (a.rid !== e.rid) begin
        $error("resting_id exp %0d got %0d", e.rid, a.rid); errors++;
      end
      if (a.iid !== e.iid) begin
        $error("incoming_id exp %0d got %0d", e.iid, a.iid); errors++;
      end
      if (a.price !== e.price) begin
        $error("fill_price exp %0d got %0d", e.price, a.price); errors++;
      end
      if (a.qty !== e.qty) begin
        $error("fill_qty exp %0d got %0d", e.qty, a.qty); errors++;
      end
      if (a.rf !== e.rf) begin
        $error("resting_filled exp %0d got %0d", e.rf, a.rf); errors++;
      end
      if (a.inf !== e.inf) begin
        $error("incoming_filled exp %0d got %0d", e.inf, a.inf); errors++;
      end
      if (a.rem !== e.rem) begin
        $error("remaining_qty exp %0d got %0d", e.rem, a.rem); errors++;
      end
      if (a.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, a.last); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        in_func = 0;
  logic        in_side = 0;
  logic [31:0] in_price = 0;
  logic [31:0] in_quantity = 0;
  logic [31:0] in_order_id = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  out_kind;
  logic [31:0] out_resting_id;
  logic [31:0] out_incoming_id;
  logic [31:0] out_fill_price;
  logic [31:0] out_fill_qty;
  logic        out_resting_filled;
  logic        out_incoming_filled;
  logic [31:0] out_remaining_qty;
  logic        out_last;

  book_scoreboard book = new();
  bit          calm;
  int          idle_cycles = 0;
  int          requests;
  logic [31:0] next_id;

  always #5 clk = ~clk;

  limit_order_book_matcher_core dut (.*);

  always @(posedge clk) begin
    report_t r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        r.kind = out_kind; r.rid = out_resting_id; r.iid = out_incoming_id;
        r.price = out_fill_price; r.qty = out_fill_qty;
        r.rf = out_resting_filled; r.inf = out_incoming_filled;
        r.rem = out_remaining_qty; r.last = out_last;
        book.check_report(r);
      end
      out_ready <= calm || ($urandom_range(99) >= 8);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // valid stays up after acceptance until the next request or an idle cycle
  task automatic send(logic func, logic side, logic [31:0] price,
                      logic [31:0] qty, logic [31:0] id);
    while (!calm && $urandom_range(99) < 8) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_func <= func; in_side <= side;
    in_price <= price; in_quantity <= qty; in_order_id <= id;
    do @(posedge clk); while (!in_ready);
    book.note_request(func, side, price, qty, id);
    requests++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (book.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_request(logic [31:0] base, int spread);
    logic [31:0] id;
    int          r;
    r = $urandom_range(99);
    if (r < 25) begin
      id = (book.oid[0].size() + book.oid[1].size() > 0 && $urandom_range(3) != 0)
           ? next_id - $urandom_range(20) : $urandom;
      send(FUNC_CANCEL, $urandom_range(1), $urandom, $urandom, id);
    end else if (r < 30) begin
      send(FUNC_NEW, $urandom_range(1), $urandom, $urandom, $urandom);
    end else begin
      send(FUNC_NEW, $urandom_range(1), base + $urandom_range(spread),
           (r < 33) ? 0 : $urandom_range(1, 200), next_id);
      next_id++;
    end
  endtask

  initial begin
    calm = 0;
    requests = 0;
    next_id = 100;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, fills, full side, duplicates, cancels
    send(FUNC_NEW, SIDE_BID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(FUNC_NEW, SIDE_ASK, 0, 32'hFFFF_FFFF, 0);
    send(FUNC_NEW, SIDE_ASK, 0, 0, 1);
    send(FUNC_CANCEL, SIDE_BID, 0, 0, 32'hDEAD_BEEF);
    for (int i = 0; i < 17; i++) send(FUNC_NEW, SIDE_ASK, 50 + (i % 3), 10, 7);
    send(FUNC_CANCEL, SIDE_ASK, 0, 0, 7);
    send(FUNC_NEW, SIDE_BID, 60, 200, 42);
    send(FUNC_CANCEL, SIDE_ASK, 0, 0, 7);
    drain();

    // no idling on either side for a stretch
    calm = 1;
    for (int i = 0; i < 60; i++) random_request(1000, 8);
    calm = 0;
    drain();

    for (int i = 0; i < 230; i++) begin
      random_request(i < 120 ? 32'h8000_0000 : 32'hFFFF_FFF0, 15);
      if (i == 100) drain();
    end
    drain();

    $display("Ran %0d requests: %0d fills, %0d cancels, %0d full-side rejects.",
             requests, book.fills, book.cancels, book.rejects);
    if (book.errors == 0 && book.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// File: sim.f
hw/rtl/lobm_pkg.sv
hw/rtl/lobm_cell.sv
hw/rtl/lobm_side.sv
hw/rtl/limit_order_book_matcher_core.sv
tb/tb_limit_order_book_matcher_core.sv
